>>> design/rft_pkg.sv
`default_nettype none
package rft_pkg;
  localparam int NUM_SLOTS = 2;
  localparam int SLOT_W = 1;
  localparam int SLOT_BYTES = 8192;
  localparam int SLOT_UNITS = SLOT_BYTES / 8;
  localparam int WORDS_PER_SLOT = (SLOT_UNITS + 63) / 64;
  localparam int WORD_W = 4;
  localparam int UNIT_W = 10;
  localparam int MEM_DEPTH = NUM_SLOTS * WORDS_PER_SLOT;
  localparam int ADDR_W = SLOT_W + WORD_W;
  localparam int LEN_W = 14;
  localparam logic [31:0] DEFAULT_TIMEOUT = 32'd3000;

  typedef enum logic [2:0] {
    OUT_STORED   = 3'd0,
    OUT_COMPLETE = 3'd1,
    OUT_TOO_LARGE = 3'd2,
    OUT_NO_SLOT  = 3'd3,
    OUT_OVERLAP  = 3'd4,
    OUT_BYPASS   = 3'd5
  } outcome_t;

  typedef enum logic [1:0] {
    KIND_FRAG   = 2'd0,
    KIND_BYPASS = 2'd1,
    KIND_BIG    = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE  = 3'd0,
    S_MATCH = 3'd1,
    S_RD    = 3'd2,
    S_CHK   = 3'd3,
    S_TOT   = 3'd4,
    S_SRD   = 3'd5,
    S_SCHK  = 3'd6
  } state_t;

  typedef struct packed {
    kind_t              kind;
    logic [31:0]        src;
    logic [31:0]        dst;
    logic [15:0]        id;
    logic [7:0]         proto;
    logic [UNIT_W-1:0]  first_unit;
    logic [UNIT_W-1:0]  last_unit;
    logic               nonempty;
    logic [LEN_W-1:0]   total_bytes;
    logic               more;
    logic [31:0]        now;
  } item_t;

  typedef struct packed {
    outcome_t          outcome;
    logic              slot;
    logic [LEN_W-1:0]  len;
  } result_t;

  function automatic logic [63:0] span_mask(input logic [5:0] lo, input logic [5:0] hi);
    span_mask = ({64{1'b1}} << lo) & ({64{1'b1}} >> (6'd63 - hi));
  endfunction
endpackage
`default_nettype wire

>>> design/rft_front.sv
`default_nettype none
module rft_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  output logic               full,
  input  wire logic [31:0]   src_ip,
  input  wire logic [31:0]   dst_ip,
  input  wire logic [15:0]   datagram_id,
  input  wire logic [7:0]    protocol,
  input  wire logic [12:0]   frag_offset_units,
  input  wire logic [15:0]   payload_bytes,
  input  wire logic          more_fragments,
  input  wire logic [31:0]   now_tick,
  output logic               item_valid,
  output rft_pkg::item_t     item,
  input  wire logic          item_take
);
  rft_pkg::item_t q [2];
  logic rd_ptr, wr_ptr;
  logic [1:0] count;
  rft_pkg::item_t cls;
  logic [13:0] units;
  logic [14:0] end_unit;
  logic [16:0] total;
  logic acc;

  always_comb begin
    units = 14'((17'(payload_bytes) + 17'd7) >> 3);
    end_unit = 15'(frag_offset_units) + 15'(units);
    total = {1'b0, frag_offset_units, 3'b000} + 17'(payload_bytes);
    cls.src = src_ip;
    cls.dst = dst_ip;
    cls.id = datagram_id;
    cls.proto = protocol;
    cls.first_unit = frag_offset_units[rft_pkg::UNIT_W-1:0];
    cls.last_unit = end_unit[rft_pkg::UNIT_W-1:0] - 10'd1;
    cls.nonempty = (payload_bytes != 16'd0);
    cls.total_bytes = total[rft_pkg::LEN_W-1:0];
    cls.more = more_fragments;
    cls.now = now_tick;
    if (frag_offset_units == 13'd0 && !more_fragments) begin
      cls.kind = rft_pkg::KIND_BYPASS;
    end else if (total > 17'(rft_pkg::SLOT_BYTES)) begin
      cls.kind = rft_pkg::KIND_BIG;
    end else begin
      cls.kind = rft_pkg::KIND_FRAG;
    end
  end

  assign full = (count == 2'd2);
  assign acc = push && !full;
  assign item_valid = (count != 2'd0);
  assign item = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (acc) begin
      q[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (acc) wr_ptr <= ~wr_ptr;
      if (item_take) rd_ptr <= ~rd_ptr;
      count <= count + 2'(acc) - 2'(item_take);
    end
  end
endmodule
`default_nettype wire

>>> design/rft_back.sv
`default_nettype none
module rft_back (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [31:0]           timeout_ticks,
  input  wire logic                  item_valid,
  input  wire rft_pkg::item_t        item,
  output logic                       item_take,
  output logic                       empty,
  input  wire logic                  pop,
  output rft_pkg::result_t           res_head
);
  localparam int NS = rft_pkg::NUM_SLOTS;

  rft_pkg::state_t state, state_next;
  rft_pkg::item_t cur;
  logic [rft_pkg::SLOT_W-1:0] s, s_next;
  logic [rft_pkg::WORD_W-1:0] w, w_next;
  logic [rft_pkg::UNIT_W-1:0] scan_last, scan_last_next;

  logic slot_busy [NS];
  logic [31:0] slot_src [NS];
  logic [31:0] slot_dst [NS];
  logic [15:0] slot_id [NS];
  logic [7:0] slot_proto [NS];
  logic [31:0] slot_last_seen [NS];
  logic [rft_pkg::LEN_W-1:0] slot_total [NS];

  logic [63:0] mem [rft_pkg::MEM_DEPTH];
  logic [rft_pkg::MEM_DEPTH-1:0] word_valid;
  logic [63:0] rdata;
  logic [rft_pkg::ADDR_W-1:0] addr;

  rft_pkg::result_t resq [2];
  logic res_rd, res_wr;
  logic [1:0] res_count;
  logic res_push;
  rft_pkg::result_t res;

  logic found_hit, free_hit, stale_hit;
  logic [rft_pkg::SLOT_W-1:0] found_idx, open_idx, aged_idx;
  logic do_alloc, do_touch, do_free, do_write, do_set_total, rd_en;
  logic [63:0] data, mask;
  logic [5:0] lo, hi;
  logic [rft_pkg::LEN_W-1:0] total_eff;
  logic [14:0] needed;

  assign addr = {s, w};

  always_comb begin
    found_hit = 1'b0;
    free_hit = 1'b0;
    stale_hit = 1'b0;
    found_idx = '0;
    open_idx = '0;
    aged_idx = '0;
    for (int i = NS - 1; i >= 0; i--) begin
      if (slot_busy[i] && slot_src[i] == cur.src && slot_dst[i] == cur.dst &&
          slot_id[i] == cur.id && slot_proto[i] == cur.proto) begin
        found_hit = 1'b1;
        found_idx = rft_pkg::SLOT_W'(i);
      end
      if (!slot_busy[i]) begin
        free_hit = 1'b1;
        open_idx = rft_pkg::SLOT_W'(i);
      end
    end
    for (int i = 0; i < NS; i++) begin
      if (slot_busy[i] && (cur.now - slot_last_seen[i]) > timeout_ticks) begin
        stale_hit = 1'b1;
        aged_idx = rft_pkg::SLOT_W'(i);
      end
    end
  end

  always_comb begin
    data = word_valid[addr] ? rdata : 64'd0;
    total_eff = cur.more ? slot_total[s] : cur.total_bytes;
    needed = (15'(total_eff) + 15'd7) >> 3;
    if (state == rft_pkg::S_CHK) begin
      lo = (w == cur.first_unit[9:6]) ? cur.first_unit[5:0] : 6'd0;
      hi = (w == cur.last_unit[9:6]) ? cur.last_unit[5:0] : 6'd63;
    end else begin
      lo = 6'd0;
      hi = (w == scan_last[9:6]) ? scan_last[5:0] : 6'd63;
    end
    mask = rft_pkg::span_mask(lo, hi);
  end

  always_comb begin
    state_next = state;
    s_next = s;
    w_next = w;
    scan_last_next = scan_last;
    item_take = 1'b0;
    res_push = 1'b0;
    res = '{outcome: rft_pkg::OUT_STORED, slot: 1'b0, len: '0};
    do_alloc = 1'b0;
    do_touch = 1'b0;
    do_free = 1'b0;
    do_write = 1'b0;
    do_set_total = 1'b0;
    rd_en = 1'b0;
    unique case (state)
      rft_pkg::S_IDLE: begin
        if (item_valid && res_count != 2'd2) begin
          item_take = 1'b1;
          unique case (item.kind)
            rft_pkg::KIND_BYPASS: begin
              res_push = 1'b1;
              res.outcome = rft_pkg::OUT_BYPASS;
            end
            rft_pkg::KIND_BIG: begin
              res_push = 1'b1;
              res.outcome = rft_pkg::OUT_TOO_LARGE;
            end
            default: state_next = rft_pkg::S_MATCH;
          endcase
        end
      end
      rft_pkg::S_MATCH: begin
        if (!found_hit && !free_hit && !stale_hit) begin
          res_push = 1'b1;
          res.outcome = rft_pkg::OUT_NO_SLOT;
          state_next = rft_pkg::S_IDLE;
        end else begin
          if (found_hit) begin
            do_touch = 1'b1;
            s_next = found_idx;
          end else begin
            do_alloc = 1'b1;
            s_next = free_hit ? open_idx : aged_idx;
          end
          w_next = cur.first_unit[9:6];
          state_next = cur.nonempty ? rft_pkg::S_RD : rft_pkg::S_TOT;
        end
      end
      rft_pkg::S_RD: begin
        rd_en = 1'b1;
        state_next = rft_pkg::S_CHK;
      end
      rft_pkg::S_CHK: begin
        if ((data & mask) != 64'd0) begin
          do_free = 1'b1;
          res_push = 1'b1;
          res.outcome = rft_pkg::OUT_OVERLAP;
          res.slot = s[0];
          state_next = rft_pkg::S_IDLE;
        end else begin
          do_write = 1'b1;
          if (w == cur.last_unit[9:6]) begin
            state_next = rft_pkg::S_TOT;
          end else begin
            w_next = w + 1'b1;
            state_next = rft_pkg::S_RD;
          end
        end
      end
      rft_pkg::S_TOT: begin
        do_set_total = !cur.more;
        if (total_eff == '0) begin
          res_push = 1'b1;
          res.slot = s[0];
          state_next = rft_pkg::S_IDLE;
        end else begin
          scan_last_next = rft_pkg::UNIT_W'(needed - 15'd1);
          w_next = '0;
          state_next = rft_pkg::S_SRD;
        end
      end
      rft_pkg::S_SRD: begin
        rd_en = 1'b1;
        state_next = rft_pkg::S_SCHK;
      end
      rft_pkg::S_SCHK: begin
        if ((data & mask) != mask) begin
          res_push = 1'b1;
          res.slot = s[0];
          state_next = rft_pkg::S_IDLE;
        end else if (w == scan_last[9:6]) begin
          do_free = 1'b1;
          res_push = 1'b1;
          res.outcome = rft_pkg::OUT_COMPLETE;
          res.slot = s[0];
          res.len = slot_total[s];
          state_next = rft_pkg::S_IDLE;
        end else begin
          w_next = w + 1'b1;
          state_next = rft_pkg::S_SRD;
        end
      end
      default: state_next = rft_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rft_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) cur <= item;
    s <= s_next;
    w <= w_next;
    scan_last <= scan_last_next;
    if (rd_en) rdata <= mem[addr];
    if (do_write) mem[addr] <= data | mask;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= '0;
      for (int i = 0; i < NS; i++) begin
        slot_busy[i] <= 1'b0;
        slot_src[i] <= '0;
        slot_dst[i] <= '0;
        slot_id[i] <= '0;
        slot_proto[i] <= '0;
        slot_last_seen[i] <= '0;
        slot_total[i] <= '0;
      end
    end else begin
      if (do_write) word_valid[addr] <= 1'b1;
      if (do_touch) slot_last_seen[s_next] <= cur.now;
      if (do_set_total) slot_total[s] <= cur.total_bytes;
      if (do_alloc) begin
        slot_busy[s_next] <= 1'b1;
        slot_src[s_next] <= cur.src;
        slot_dst[s_next] <= cur.dst;
        slot_id[s_next] <= cur.id;
        slot_proto[s_next] <= cur.proto;
        slot_last_seen[s_next] <= cur.now;
        slot_total[s_next] <= '0;
        for (int j = 0; j < rft_pkg::WORDS_PER_SLOT; j++) begin
          word_valid[{s_next, rft_pkg::WORD_W'(j)}] <= 1'b0;
        end
      end
      if (do_free) begin
        slot_busy[s] <= 1'b0;
        slot_last_seen[s] <= '0;
        slot_total[s] <= '0;
        for (int j = 0; j < rft_pkg::WORDS_PER_SLOT; j++) begin
          word_valid[{s, rft_pkg::WORD_W'(j)}] <= 1'b0;
        end
      end
    end
  end

  assign empty = (res_count == 2'd0);
  assign res_head = resq[res_rd];

  always_ff @(posedge clk) begin
    if (res_push) resq[res_wr] <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_rd <= 1'b0;
      res_wr <= 1'b0;
      res_count <= 2'd0;
    end else begin
      if (res_push) res_wr <= ~res_wr;
      if (pop && !empty) res_rd <= ~res_rd;
      res_count <= res_count + 2'(res_push) - 2'(pop && !empty);
    end
  end
endmodule
`default_nettype wire

>>> design/ipv4_fragment_reassembly_tracker.sv
`default_nettype none
// Channel   Direction  Handshake                Payload
// input     in         push / full              src_ip .. now_tick
// result    out        empty / pop              outcome, slot_index, datagram_len
// config    in         cfg_valid / cfg_ready    cfg_data (timeout_ticks)
//
// A stored or completed fragment walks 64-bit coverage words in two passes, once for the
// overlap check and marking and once for the completion scan; an overlap ends the walk
// at the word where it is found.
// Unfragmented and oversized items are resolved in the idle state as they are taken.
// Reset is synchronous and leaves all slots free with no clearing pass.
// A two-entry queue on each side lets input and results stall independently.
module ipv4_fragment_reassembly_tracker (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  output logic              full,
  input  wire logic [31:0]  src_ip,
  input  wire logic [31:0]  dst_ip,
  input  wire logic [15:0]  datagram_id,
  input  wire logic [7:0]   protocol,
  input  wire logic [12:0]  frag_offset_units,
  input  wire logic [15:0]  payload_bytes,
  input  wire logic         more_fragments,
  input  wire logic [31:0]  now_tick,
  output logic              empty,
  input  wire logic         pop,
  output logic [2:0]        outcome,
  output logic              slot_index,
  output logic [13:0]       datagram_len,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [31:0]  cfg_data
);
  logic [31:0] timeout_ticks;
  logic item_valid, item_take;
  rft_pkg::item_t item;
  rft_pkg::result_t res_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= rft_pkg::DEFAULT_TIMEOUT;
    end else if (cfg_valid) begin
      timeout_ticks <= cfg_data;
    end
  end

  rft_front u_front (
    .clk, .rst, .push, .full, .src_ip, .dst_ip, .datagram_id, .protocol,
    .frag_offset_units, .payload_bytes, .more_fragments, .now_tick,
    .item_valid, .item, .item_take
  );

  rft_back u_back (
    .clk, .rst, .timeout_ticks, .item_valid, .item, .item_take,
    .empty, .pop, .res_head
  );

  assign outcome = res_head.outcome;
  assign slot_index = res_head.slot;
  assign datagram_len = res_head.len;
endmodule
`default_nettype wire

>>> test/ipv4_fragment_reassembly_checker.sv
`timescale 1ns / 100ps
module ipv4_fragment_reassembly_checker (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire logic         full,
  input  wire logic [31:0]  src_ip,
  input  wire logic [31:0]  dst_ip,
  input  wire logic [15:0]  datagram_id,
  input  wire logic [7:0]   protocol,
  input  wire logic [12:0]  frag_offset_units,
  input  wire logic [15:0]  payload_bytes,
  input  wire logic         more_fragments,
  input  wire logic [31:0]  now_tick,
  input  wire logic         empty,
  input  wire logic         pop,
  input  wire logic [2:0]   outcome,
  input  wire logic         slot_index,
  input  wire logic [13:0]  datagram_len,
  input  wire logic         cfg_valid,
  input  wire logic         cfg_ready,
  input  wire logic [31:0]  cfg_data,
  output int                fail_count,
  output int                pending
);

  typedef struct {
    rft_pkg::outcome_t outcome;
    bit                slot;
    bit [13:0]         len;
  } verdict_t;

  verdict_t       verdict_q[$];
  bit [31:0]      timeout_val;
  bit             busy [rft_pkg::NUM_SLOTS];
  bit [31:0]      key_src [rft_pkg::NUM_SLOTS];
  bit [31:0]      key_dst [rft_pkg::NUM_SLOTS];
  bit [15:0]      key_id [rft_pkg::NUM_SLOTS];
  bit [7:0]       key_proto [rft_pkg::NUM_SLOTS];
  bit [31:0]      last_seen [rft_pkg::NUM_SLOTS];
  bit [31:0]      want_total [rft_pkg::NUM_SLOTS];
  bit [rft_pkg::SLOT_UNITS-1:0] coverage [rft_pkg::NUM_SLOTS];

  initial begin
    fail_count = 0;
    pending = 0;
    timeout_val = rft_pkg::DEFAULT_TIMEOUT;
    for (int s = 0; s < rft_pkg::NUM_SLOTS; s++) begin
      busy[s] = 0;
      key_src[s] = 0;
      key_dst[s] = 0;
      key_id[s] = 0;
      key_proto[s] = 0;
      last_seen[s] = 0;
      want_total[s] = 0;
      coverage[s] = '0;
    end
  end

  task automatic release_slot(input int s);
    busy[s] = 0;
    want_total[s] = 0;
    last_seen[s] = 0;
    coverage[s] = '0;
  endtask

  task automatic predict_fragment(output verdict_t v);
    bit [31:0] off_bytes;
    bit [31:0] units;
    bit [31:0] stop;
    bit [31:0] needed;
    int found;
    int open_idx;
    int aged_idx;
    int s;
    bit hit;
    bit all;
    found = -1;
    open_idx = -1;
    aged_idx = -1;
    v.outcome = rft_pkg::OUT_STORED;
    v.slot = 0;
    v.len = 0;
    off_bytes = 32'(frag_offset_units) * 8;
    if (frag_offset_units == 0 && !more_fragments) begin
      v.outcome = rft_pkg::OUT_BYPASS;
      return;
    end
    if (off_bytes + 32'(payload_bytes) > rft_pkg::SLOT_BYTES) begin
      v.outcome = rft_pkg::OUT_TOO_LARGE;
      return;
    end
    for (int i = 0; i < rft_pkg::NUM_SLOTS; i++) begin
      if (busy[i] && key_src[i] == src_ip && key_dst[i] == dst_ip &&
          key_id[i] == datagram_id && key_proto[i] == protocol) begin
        found = i;
        break;
      end
      if (!busy[i] && open_idx < 0) open_idx = i;
      else if (busy[i] && (now_tick - last_seen[i]) > timeout_val) aged_idx = i;
    end
    if (found >= 0) begin
      s = found;
      last_seen[s] = now_tick;
    end else begin
      s = (open_idx >= 0) ? open_idx : aged_idx;
      if (s < 0) begin
        v.outcome = rft_pkg::OUT_NO_SLOT;
        return;
      end
      release_slot(s);
      busy[s] = 1;
      key_src[s] = src_ip;
      key_dst[s] = dst_ip;
      key_id[s] = datagram_id;
      key_proto[s] = protocol;
      last_seen[s] = now_tick;
    end
    v.slot = s[0];
    units = (32'(payload_bytes) + 7) / 8;
    stop = 32'(frag_offset_units) + units;
    if (stop > rft_pkg::SLOT_UNITS) stop = rft_pkg::SLOT_UNITS;
    hit = 0;
    for (bit [31:0] u = frag_offset_units; u < stop; u++)
      if (coverage[s][u]) hit = 1;
    if (hit) begin
      release_slot(s);
      v.outcome = rft_pkg::OUT_OVERLAP;
      return;
    end
    for (bit [31:0] u = frag_offset_units; u < stop; u++) coverage[s][u] = 1;
    if (!more_fragments) want_total[s] = off_bytes + 32'(payload_bytes);
    if (want_total[s] != 0) begin
      needed = (want_total[s] + 7) / 8;
      if (needed <= rft_pkg::SLOT_UNITS) begin
        all = 1;
        for (bit [31:0] u = 0; u < needed; u++)
          if (!coverage[s][u]) all = 0;
        if (all) begin
          v.outcome = rft_pkg::OUT_COMPLETE;
          v.len = want_total[s][13:0];
          release_slot(s);
        end
      end
    end
  endtask

  task automatic report(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    verdict_t v;
    if (!rst) begin
      if (cfg_valid && cfg_ready) timeout_val = cfg_data;
      if (push && !full) begin
        predict_fragment(v);
        verdict_q.push_back(v);
      end
      if (pop && !empty) begin
        if (verdict_q.size() == 0) begin
          report("unexpected result, outcome", outcome, -1);
        end else begin
          v = verdict_q.pop_front();
          if (outcome != v.outcome) report("outcome", outcome, v.outcome);
          if (slot_index != v.slot) report("slot_index", slot_index, v.slot);
          if (datagram_len != v.len) report("datagram_len", datagram_len, v.len);
        end
      end
    end
    pending = verdict_q.size();
  end

endmodule

>>> test/tb_ipv4_fragment_reassembly_tracker.sv
`timescale 1ns / 100ps
module tb_ipv4_fragment_reassembly_tracker;

  typedef struct {
    bit [31:0] src;
    bit [31:0] dst;
    bit [15:0] id;
    bit [7:0]  proto;
  } flow_key_t;

  logic         clk = 0;
  logic         rst = 1;
  logic         push = 0;
  logic         full;
  logic [31:0]  src_ip = 0;
  logic [31:0]  dst_ip = 0;
  logic [15:0]  datagram_id = 0;
  logic [7:0]   protocol = 0;
  logic [12:0]  frag_offset_units = 0;
  logic [15:0]  payload_bytes = 0;
  logic         more_fragments = 0;
  logic [31:0]  now_tick = 0;
  logic         empty;
  logic         pop = 0;
  logic [2:0]   outcome;
  logic         slot_index;
  logic [13:0]  datagram_len;
  logic         cfg_valid = 0;
  logic         cfg_ready;
  logic [31:0]  cfg_data = 0;
  int           fail_count;
  int           pending;
  bit           steady = 0;
  bit [31:0]    tick = 32'hFFFF_F000;
  int           sent = 0;
  int           stall_cycles = 0;
  flow_key_t    flows [4];

  ipv4_fragment_reassembly_tracker u_dut (.*);

  ipv4_fragment_reassembly_checker u_chk (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) pop <= 0;
    else pop <= steady || ($urandom_range(0, 99) >= 7);
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= 20000) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send(input flow_key_t k, input int off, input int plen, input bit mf);
    if (!steady) begin
      while ($urandom_range(0, 99) < 7) begin
        push <= 0;
        @(posedge clk);
      end
    end
    push <= 1;
    src_ip <= k.src;
    dst_ip <= k.dst;
    datagram_id <= k.id;
    protocol <= k.proto;
    frag_offset_units <= off[12:0];
    payload_bytes <= plen[15:0];
    more_fragments <= mf;
    now_tick <= tick;
    @(posedge clk);
    while (full) @(posedge clk);
    sent++;
  endtask

  task automatic drain_and_settle;
    push <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_timeout(input bit [31:0] value);
    drain_and_settle();
    cfg_valid <= 1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
  endtask

  function automatic flow_key_t random_key();
    flow_key_t k;
    k.src = $urandom;
    k.dst = $urandom;
    k.id = 16'($urandom);
    k.proto = 8'($urandom);
    return k;
  endfunction

  task automatic send_datagram(input flow_key_t k);
    int n;
    int last_bytes;
    int off_q[$];
    int len_q[$];
    int pos;
    int cut;
    int j;
    int t;
    int idx;
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(64, rft_pkg::SLOT_UNITS)
                                     : $urandom_range(1, 40);
    last_bytes = $urandom_range(1, 8);
    pos = 0;
    while (pos < n) begin
      cut = $urandom_range(1, (n - pos < 12) ? n - pos : 12);
      if (n > 64 && $urandom_range(0, 1)) cut = n - pos;
      off_q.push_back(pos);
      len_q.push_back(cut);
      pos += cut;
    end
    for (int i = off_q.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = off_q[i]; off_q[i] = off_q[j]; off_q[j] = t;
      t = len_q[i]; len_q[i] = len_q[j]; len_q[j] = t;
    end
    if ($urandom_range(0, 9) == 0) begin
      void'(off_q.pop_back());
      void'(len_q.pop_back());
    end
    if ($urandom_range(0, 9) == 0 && off_q.size() > 0) begin
      idx = $urandom_range(0, off_q.size() - 1);
      off_q.push_back(off_q[idx]);
      len_q.push_back(len_q[idx]);
    end
    for (int i = 0; i < off_q.size(); i++) begin
      tick += $urandom_range(0, 40);
      if (off_q[i] + len_q[i] == n)
        send(k, off_q[i], (len_q[i] - 1) * 8 + last_bytes, 0);
      else
        send(k, off_q[i], len_q[i] * 8, 1);
    end
  endtask

  task automatic random_phase(input int count);
    int stop_at;
    int r;
    stop_at = sent + count;
    while (sent < stop_at) begin
      steady = (sent % 300) > 200;
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 29) == 0) flows[$urandom_range(0, 3)] = random_key();
      if ($urandom_range(0, 49) == 0) tick += $urandom_range(2000, 6000);
      if (r < 75) begin
        send_datagram(flows[$urandom_range(0, 3)]);
      end else if (r < 90) begin
        tick += $urandom_range(0, 100);
        send(flows[$urandom_range(0, 3)], $urandom_range(0, 200), $urandom_range(0, 300),
             1'($urandom_range(0, 1)));
      end else begin
        tick += $urandom;
        send(random_key(), $urandom_range(0, 8191), $urandom_range(0, 65535),
             1'($urandom_range(0, 1)));
      end
    end
    steady = 0;
  endtask

  initial begin
    flow_key_t ka;
    flow_key_t kb;
    flow_key_t kc;
    flow_key_t kd;
    flow_key_t ke;
    ka = random_key();
    kb = random_key();
    kc = random_key();
    kd = random_key();
    ke = random_key();
    for (int i = 0; i < 4; i++) flows[i] = random_key();
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send(ka, 0, 100, 0);
    send(ka, 8191, 65535, 1);
    send(ka, 8191, 0, 1);
    send(ka, 0, 0, 1);
    send(ka, 0, 16, 1);
    send(ka, 2, 8, 0);
    send(kb, 0, 64, 1);
    send(kc, 10, 8, 1);
    send(kd, 0, 8, 1);
    send(kb, 4, 8, 1);
    send(kd, 1023, 8, 0);
    send(kd, 0, 8184, 1);
    tick += 4000;
    send(kc, 11, 8, 1);
    send(ke, 0, 8, 1);
    tick += 4000;
    send(ka, 1024, 0, 0);
    send(ke, 5, 8, 0);
    send(ke, 3, 8, 0);
    send(ke, 1, 16, 1);
    send(ka, 0, 65535, 1);
    send(kb, 1023, 9, 0);

    write_timeout(32'd0);
    random_phase(200);
    write_timeout(32'hFFFF_FFFF);
    random_phase(200);
    write_timeout($urandom_range(0, 500));
    random_phase(200);
    write_timeout(rft_pkg::DEFAULT_TIMEOUT);
    random_phase(230);

    drain_and_settle();
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/rft_pkg.sv
design/rft_front.sv
design/rft_back.sv
design/ipv4_fragment_reassembly_tracker.sv
test/ipv4_fragment_reassembly_checker.sv
test/tb_ipv4_fragment_reassembly_tracker.sv
